/* rtl/core/ffa_pkg.sv */
// Shared types and codes for the first-fit free-list allocator.
`default_nettype none
package ffa_pkg;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_PAD   = 2'd1,
    STATUS_NOFIT = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  localparam int SIZE_W  = 13;
  localparam int ALIGN_W = 4;
  localparam int ADDR_W  = 12;

endpackage
`default_nettype wire

/* rtl/core/ffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/ffa_alu.sv */
// Shared add/subtract unit with a less-than flag on its operands.
`default_nettype none
module ffa_alu #(
  parameter int W = 20
) (
  input  wire ffa_pkg::alu_op_t op,
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output logic      [W-1:0]     res,
  output logic                  lt
);
  import ffa_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
    lt = (a < b);
  end
endmodule
`default_nettype wire

/* rtl/core/first_fit_free_list_allocator_unit.sv */
// Top level: sequencer, list registers and stores of the first-fit allocator.
// Allocate: walks the free list from its head, skipping free blocks that are too small;
//   a padding refusal ends before the walk, and a failed walk ends with NOFIT.
// Free: walks past the free blocks below the freed address, then merges; an ignored one skips the walk.
// One item at a time: input reopens in the same cycle as the result is posted; a stalled
//   result delays the next one. Reset is synchronous; state S_INIT then sets up the arena.
`default_nettype none
module first_fit_free_list_allocator_unit #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int NODE_BYTES   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    request_size,
  input  wire logic [ffa_pkg::ALIGN_W-1:0]   alignment_log2,
  input  wire logic [ffa_pkg::ADDR_W-1:0]    block_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [ffa_pkg::ADDR_W-1:0]         payload_address
);
  import ffa_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int DW = AW + 1;
  localparam int CW = ((DW > 17) ? DW : 17) + 3;
  localparam logic [CW-1:0] ARENA_C  = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HEADER_C = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] NODE1_C  = CW'(NODE_BYTES + 1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, A_POS, A_CHK, A_NEED, A_ISSUE, A_CMP, A_T1, A_PIECE, A_NODE,
    A_W1, A_W2, A_W3, F_CHK, F_ISSUE, F_NXT, F_LINK, F_LINK2, F_MR1, F_MR2,
    F_MR3, F_MP1, F_MP2, F_MP3, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] req_size, pad, need, piece, node, cur, prev, cur_size, cur_next;
  logic [CW-1:0] size_node, node_next, e1, addr_q, head;
  logic [ALIGN_W-1:0] lg;
  logic [DW-1:0] steps;
  logic have_prev, split, merge;
  logic [1:0] res_status;
  logic [ADDR_W-1:0] res_payload;

  logic [CW-1:0] align, mask;
  alu_op_t alu_op;
  logic [CW-1:0] alu_a, alu_b, alu_res;
  logic alu_lt;

  logic size_we, next_we;
  logic [AW-1:0] size_wa, next_wa, size_ra, next_ra;
  logic [DW-1:0] size_wd, next_wd, size_q, next_q;
  logic [CW-1:0] follow;

  assign align  = CW'(1) << lg;
  assign mask   = align - CW'(1);
  assign follow = split ? node : cur_next;

  ffa_alu #(.W(CW)) u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res), .lt(alu_lt)
  );

  ffa_ram #(.WIDTH(DW), .DEPTH(ARENA_BYTES)) u_size_ram (
    .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
    .raddr(size_ra), .rdata(size_q)
  );

  ffa_ram #(.WIDTH(DW), .DEPTH(ARENA_BYTES)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(next_ra), .rdata(next_q)
  );

  assign in_stall = (state != S_IDLE);

  // Operand selection for the shared unit and store port control.
  always_comb begin
    alu_op  = ALU_ADD;
    alu_a   = '0;
    alu_b   = '0;
    size_we = 1'b0;
    next_we = 1'b0;
    size_wa = '0;
    next_wa = '0;
    size_wd = '0;
    next_wd = '0;
    size_ra = cur[AW-1:0];
    next_ra = cur[AW-1:0];
    unique case (state)
      S_INIT: begin
        size_we = 1'b1;
        size_wd = DW'(ARENA_BYTES - HEADER_BYTES);
        next_we = 1'b1;
        next_wd = DW'(ARENA_BYTES);
      end
      A_POS:   begin alu_a = HEADER_C; alu_b = req_size; end
      A_CHK:   begin alu_a = pad; alu_b = HEADER_C; end
      A_NEED:  begin alu_a = req_size; alu_b = pad; end
      A_CMP:   begin alu_a = CW'(size_q); alu_b = need; end
      A_T1:    begin alu_a = need; alu_b = NODE1_C; end
      A_PIECE: begin alu_a = need; alu_b = HEADER_C; end
      A_NODE:  begin alu_a = cur; alu_b = piece; end
      A_W1: begin
        alu_op  = ALU_SUB;
        alu_a   = cur_size;
        alu_b   = piece;
        size_we = split;
        size_wa = node[AW-1:0];
        size_wd = alu_res[DW-1:0];
        next_we = split;
        next_wa = node[AW-1:0];
        next_wd = cur_next[DW-1:0];
      end
      A_W2: begin
        size_we = 1'b1;
        size_wa = cur[AW-1:0];
        size_wd = split ? need[DW-1:0] : cur_size[DW-1:0];
        next_we = split;
        next_wa = cur[AW-1:0];
        next_wd = node[DW-1:0];
      end
      A_W3: begin
        alu_a   = cur;
        alu_b   = HEADER_C;
        next_we = have_prev;
        next_wa = prev[AW-1:0];
        next_wd = follow[DW-1:0];
      end
      F_CHK: begin alu_op = ALU_SUB; alu_a = addr_q; alu_b = HEADER_C; end
      F_LINK: begin
        next_we = 1'b1;
        next_wa = node[AW-1:0];
        next_wd = cur[DW-1:0];
        size_ra = node[AW-1:0];
      end
      F_LINK2: begin
        next_we = have_prev;
        next_wa = prev[AW-1:0];
        next_wd = node[DW-1:0];
      end
      F_MR1: begin alu_a = size_node; alu_b = HEADER_C; end
      F_MR2: begin alu_a = node; alu_b = e1; end
      F_MR3: begin
        alu_a   = e1;
        alu_b   = cur_size;
        size_we = merge;
        size_wa = node[AW-1:0];
        size_wd = alu_res[DW-1:0];
        next_we = merge;
        next_wa = node[AW-1:0];
        next_wd = cur_next[DW-1:0];
        size_ra = prev[AW-1:0];
      end
      F_MP1: begin alu_a = CW'(size_q); alu_b = HEADER_C; end
      F_MP2: begin alu_a = prev; alu_b = e1; end
      F_MP3: begin
        alu_a   = e1;
        alu_b   = size_node;
        size_we = merge;
        size_wa = prev[AW-1:0];
        size_wd = alu_res[DW-1:0];
        next_we = merge;
        next_wa = prev[AW-1:0];
        next_wd = node_next[DW-1:0];
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          head  <= '0;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_size    <= CW'(request_size);
            lg          <= alignment_log2;
            addr_q      <= CW'(block_address);
            res_status  <= STATUS_OK;
            res_payload <= '0;
            state       <= (kind == KIND_FREE) ? F_CHK : A_POS;
          end
        end
        A_POS: begin
          pad   <= (~alu_res + CW'(1)) & mask;
          state <= A_CHK;
        end
        A_CHK: begin
          if (alu_res > (align << 1)) begin
            res_status <= STATUS_PAD;
            state      <= S_DONE;
          end else begin
            state <= A_NEED;
          end
        end
        A_NEED: begin
          need      <= alu_res;
          cur       <= head;
          steps     <= '0;
          have_prev <= 1'b0;
          state     <= A_ISSUE;
        end
        A_ISSUE: begin
          if (cur >= ARENA_C) begin
            res_status <= STATUS_NOFIT;
            state      <= S_DONE;
          end else begin
            state <= A_CMP;
          end
        end
        A_CMP: begin
          if (!alu_lt) begin
            cur_size <= CW'(size_q);
            cur_next <= CW'(next_q);
            state    <= A_T1;
          end else if (steps >= DW'(ARENA_BYTES)) begin
            res_status <= STATUS_NOFIT;
            state      <= S_DONE;
          end else begin
            steps     <= steps + DW'(1);
            prev      <= cur;
            have_prev <= 1'b1;
            cur       <= CW'(next_q);
            state     <= A_ISSUE;
          end
        end
        A_T1: begin
          split <= (cur_size >= alu_res);
          state <= A_PIECE;
        end
        A_PIECE: begin
          piece <= alu_res;
          state <= A_NODE;
        end
        A_NODE: begin
          node  <= alu_res;
          split <= split && (alu_res < ARENA_C);
          state <= A_W1;
        end
        A_W1: state <= A_W2;
        A_W2: state <= A_W3;
        A_W3: begin
          if (!have_prev) begin
            head <= follow;
          end
          res_payload <= alu_res[ADDR_W-1:0];
          state       <= S_DONE;
        end
        F_CHK: begin
          node      <= alu_res;
          cur       <= head;
          steps     <= '0;
          have_prev <= 1'b0;
          // Addresses below the first header, or past the arena, are ignored.
          if (alu_lt || (alu_res >= ARENA_C)) begin
            state <= S_DONE;
          end else begin
            state <= F_ISSUE;
          end
        end
        F_ISSUE: begin
          if ((cur < ARENA_C) && (cur < node) && (steps < DW'(ARENA_BYTES))) begin
            state <= F_NXT;
          end else begin
            state <= F_LINK;
          end
        end
        F_NXT: begin
          prev      <= cur;
          have_prev <= 1'b1;
          steps     <= steps + DW'(1);
          cur       <= CW'(next_q);
          state     <= F_ISSUE;
        end
        F_LINK: begin
          node_next <= cur;
          state     <= F_LINK2;
        end
        F_LINK2: begin
          size_node <= CW'(size_q);
          if (!have_prev) begin
            head <= node;
          end
          state <= F_MR1;
        end
        F_MR1: begin
          cur_size <= CW'(size_q);
          cur_next <= CW'(next_q);
          e1       <= alu_res;
          state    <= F_MR2;
        end
        F_MR2: begin
          merge <= (cur < ARENA_C) && (alu_res == cur);
          state <= F_MR3;
        end
        F_MR3: begin
          if (merge) begin
            size_node <= alu_res;
            node_next <= cur_next;
          end
          state <= F_MP1;
        end
        F_MP1: begin
          e1    <= alu_res;
          state <= F_MP2;
        end
        F_MP2: begin
          merge <= have_prev && (alu_res == node);
          state <= F_MP3;
        end
        F_MP3: state <= S_DONE;
        S_DONE: begin
          // The result register frees up when the pending transfer completes.
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            payload_address <= res_payload;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the first-fit free-list allocator unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int ARENA = 4096;
  localparam int HDR = 16;
  localparam int NODE = 16;
  localparam int IDLE_LIMIT = 30000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    kind_t kind;
    logic [SIZE_W-1:0] size;
    logic [ALIGN_W-1:0] align_log2;
    logic [ADDR_W-1:0] addr;
  } alloc_req_t;

  typedef struct packed {
    status_t status;
    logic [ADDR_W-1:0] addr;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [SIZE_W-1:0] request_size = '0;
  logic [ALIGN_W-1:0] alignment_log2 = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [ADDR_W-1:0] payload_address;

  first_fit_free_list_allocator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .request_size(request_size),
    .alignment_log2(alignment_log2), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .payload_address(payload_address)
  );

  // Two copies of the arena bookkeeping: copy 0 steers stimulus generation,
  // copy 1 predicts responses as transfers are accepted.
  int unsigned free_head [2];
  int unsigned blk_size [2][ARENA];
  int unsigned next_link [2][ARENA];
  bit hdr_written [2][ARENA];

  alloc_req_t pending_reqs [$];
  alloc_resp_t expected_resps [$];
  int live_blocks [$];
  int released_blocks [$];

  int errors = 0;
  int reqs_taken = 0;
  int resps_seen = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int burst_left = 4;
  int gap_left = 0;
  int cyc = 0;
  int n_ok = 0, n_pad = 0, n_nofit = 0, n_free = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic void reset_arena(input int m);
    for (int i = 0; i < ARENA; i++) begin
      blk_size[m][i] = 0;
      next_link[m][i] = 0;
      hdr_written[m][i] = 1'b0;
    end
    free_head[m] = 0;
    blk_size[m][0] = ARENA - HDR;
    next_link[m][0] = ARENA;
    hdr_written[m][0] = 1'b1;
  endfunction

  function automatic alloc_resp_t arena_step(input int m, input alloc_req_t r);
    alloc_resp_t res;
    int unsigned align, pos, pad, need, cur, prev, steps, cur_size, total, node;
    bit have_prev;
    res.status = STATUS_OK;
    res.addr = '0;
    prev = 0;
    steps = 0;
    have_prev = 1'b0;
    if (r.kind == KIND_ALLOC) begin
      align = 1 << r.align_log2;
      pos = HDR + r.size;
      pad = (align - (pos & (align - 1))) & (align - 1);
      if (pad + HDR > 2 * align) begin
        res.status = STATUS_PAD;
        return res;
      end
      need = r.size + pad;
      cur = free_head[m];
      while (cur < ARENA && blk_size[m][cur] < need) begin
        if (steps >= ARENA) begin
          cur = ARENA;
          break;
        end
        steps++;
        prev = cur;
        have_prev = 1'b1;
        cur = next_link[m][cur];
      end
      if (cur >= ARENA) begin
        res.status = STATUS_NOFIT;
        return res;
      end
      cur_size = blk_size[m][cur];
      total = need;
      node = cur + HDR + need;
      if (cur_size >= need + NODE + 1 && node < ARENA) begin
        blk_size[m][node] = cur_size - (HDR + need);
        hdr_written[m][node] = 1'b1;
        next_link[m][node] = next_link[m][cur];
        next_link[m][cur] = node;
      end else begin
        total = cur_size;
      end
      if (have_prev) next_link[m][prev] = next_link[m][cur];
      else free_head[m] = next_link[m][cur];
      blk_size[m][cur] = total;
      hdr_written[m][cur] = 1'b1;
      res.addr = ADDR_W'(cur + HDR);
    end else begin
      if (r.addr < HDR) return res;
      node = r.addr - HDR;
      cur = free_head[m];
      while (cur < ARENA && cur < node && steps < ARENA) begin
        steps++;
        prev = cur;
        have_prev = 1'b1;
        cur = next_link[m][cur];
      end
      next_link[m][node] = cur;
      if (have_prev) next_link[m][prev] = node;
      else free_head[m] = node;
      // Merge with the following free block, then with the preceding one.
      if (cur < ARENA && node + HDR + blk_size[m][node] == cur) begin
        blk_size[m][node] += HDR + blk_size[m][cur];
        next_link[m][node] = next_link[m][cur];
      end
      if (have_prev && prev + HDR + blk_size[m][prev] == node) begin
        blk_size[m][prev] += HDR + blk_size[m][node];
        next_link[m][prev] = next_link[m][node];
      end
    end
    return res;
  endfunction

  // Queues one request, unless it would free an unwritten header, and keeps the generator's view of the arena current.
  task automatic queue_req(input kind_t k, input int size, input int al, input int addr);
    alloc_req_t r;
    alloc_resp_t res;
    r.kind = k;
    r.size = SIZE_W'(size);
    r.align_log2 = ALIGN_W'(al);
    r.addr = ADDR_W'(addr);
    // Never free a header that has not been written.
    if (k == KIND_FREE && addr >= HDR && !hdr_written[0][addr - HDR]) return;
    res = arena_step(0, r);
    if (k == KIND_ALLOC && res.status == STATUS_OK) live_blocks = {live_blocks, int'(res.addr)};
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic queue_live_free(input int idx);
    int a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    released_blocks = {released_blocks, a};
    queue_req(KIND_FREE, 0, 0, a);
  endtask

  function automatic int pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 64);
    if (p < 95) return $urandom_range(0, 400);
    if (p < 98) return $urandom_range(0, 4096);
    return 4096;
  endfunction

  function automatic int pick_align();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(4, 7);
    if (p < 95) return $urandom_range(0, 3);
    return $urandom_range(8, 12);
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    alloc_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r.kind = kind_t'(kind);
        r.size = request_size;
        r.align_log2 = alignment_log2;
        r.addr = block_address;
        expected_resps = {expected_resps, arena_step(1, r)};
        reqs_taken++;
      end
      if (in_valid && in_stall) begin
        // Hold the stalled payload.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        kind <= r.kind;
        request_size <= r.size;
        alignment_log2 <= r.align_log2;
        block_address <= r.addr;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off to back the block up.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && reqs_taken >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case ((cyc >> 9) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  // Monitor: compare each accepted response with the oldest prediction.
  always @(posedge clk) begin
    alloc_resp_t e;
    if (!rst && out_valid && !out_stall) begin
      resps_seen++;
      if (expected_resps.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: status %0d addr %0d",
                                  status, payload_address));
      end else begin
        e = expected_resps.pop_front();
        case (e.status)
          STATUS_OK: n_ok++;
          STATUS_PAD: n_pad++;
          default: n_nofit++;
        endcase
        if (status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
        if (payload_address !== e.addr)
          report_mismatch($sformatf("payload_address %0d, expected %0d",
                                    payload_address, e.addr));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d responses outstanding", expected_resps.size());
      $display("first_fit_free_list_allocator_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p, a;
    reset_arena(0);
    reset_arena(1);

    // Directed: alignment failures, whole-arena requests, merges on both sides.
    queue_req(KIND_ALLOC, 10, 0, 0);
    queue_req(KIND_ALLOC, 10, 1, 0);
    queue_req(KIND_ALLOC, 10, 2, 0);
    queue_req(KIND_ALLOC, 1, 3, 0);
    queue_req(KIND_ALLOC, 0, 3, 0);
    queue_req(KIND_ALLOC, 4096, 4, 0);
    queue_req(KIND_ALLOC, 48, 4, 0);
    queue_req(KIND_ALLOC, 100, 5, 0);
    queue_req(KIND_ALLOC, 7, 12, 0);
    queue_req(KIND_ALLOC, 32, 4, 0);
    queue_req(KIND_FREE, 0, 0, 5);
    queue_req(KIND_FREE, 0, 0, 0);
    queue_live_free(1);
    queue_live_free(0);
    queue_live_free(1);
    queue_live_free(0);
    queue_req(KIND_ALLOC, 4080, 4, 0);
    queue_live_free(0);
    // Leaves a remainder too small to split, so the block is handed out whole.
    queue_req(KIND_ALLOC, 4064, 4, 0);
    queue_req(KIND_ALLOC, 0, 4, 0);
    queue_live_free(0);
    queue_req(KIND_ALLOC, 8191 & 4095, 15 & 7, 0);
    queue_req(KIND_FREE, 0, 0, 4095 & 15);

    while (pending_reqs.size() < 1950) begin
      p = $urandom_range(0, 999);
      if (p < 10) begin
        queue_req(KIND_FREE, 0, 0, $urandom_range(0, HDR - 1));
      end else if (p < 14 && released_blocks.size() > 0) begin
        // Repeated free of an earlier block; the list is not checked for this.
        a = released_blocks[$urandom_range(0, released_blocks.size() - 1)];
        queue_req(KIND_FREE, 0, 0, a);
      end else if (live_blocks.size() > 0 &&
                   $urandom_range(0, 99) < (live_blocks.size() > 12 ? 70 : 40)) begin
        queue_live_free($urandom_range(0, live_blocks.size() - 1));
      end else begin
        queue_req(KIND_ALLOC, pick_size(), pick_align(), 0);
      end
    end
    n_free = 0;
    foreach (pending_reqs[i]) if (pending_reqs[i].kind == KIND_FREE) n_free++;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d requests (%0d frees); %0d responses checked.",
             reqs_taken, n_free, resps_seen);
    $display("Allocations: %0d granted, %0d refused for padding, %0d with no fit.",
             n_ok - n_free, n_pad, n_nofit);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("first_fit_free_list_allocator_unit verification clean");
    end else begin
      $display("first_fit_free_list_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* first_fit_free_list_allocator_unit.f */
rtl/core/ffa_pkg.sv
rtl/core/ffa_ram.sv
rtl/core/ffa_alu.sv
rtl/core/first_fit_free_list_allocator_unit.sv
dv/tb.sv
